// File: hdl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg - shared types and constants of the axis-angle rotation unit
// Word layouts between front end, queue and back end, Q5.30 and Q4.30 constants and
// the arctangent table of the sine/cosine stages.
// ----------------------------------------------------------------------------
package aavr_pkg;

	localparam int W            = 32;
	localparam int ANG_W        = 19;
	localparam int T_W          = 35;
	localparam int CS_W         = 34;
	localparam int R_W          = 40;
	localparam int SQ_STEPS     = 32;
	localparam int DIV_STEPS    = 31;
	localparam int CORDIC_STEPS = 30;

	localparam logic signed [T_W-1:0]  PI_Q30      = 35'sd3373259426;
	localparam logic signed [T_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [CS_W-1:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [CS_W-1:0] ONE_Q30     = 34'sd1073741824;
	localparam logic [W-1:0]           Q_MAX       = 32'h7FFF_FFFF;
	localparam logic [W-1:0]           Q_MIN       = 32'h8000_0000;

	typedef struct packed {
		logic [2:0][W-1:0]       vec;
		logic [2:0][W-1:0]       mag;
		logic [2:0]              neg;
		logic                    zero;
		logic signed [ANG_W-1:0] angle;
	} item_t;

	typedef struct packed {
		logic [2:0][W-1:0] vout;
		logic              axis_zero;
		logic              saturated;
	} res_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			5'd24: r = 30'd63;
			5'd25: r = 30'd31;
			5'd26: r = 30'd15;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/aavr_front.sv
// ----------------------------------------------------------------------------
// aavr_front - input stage of the rotation unit
// Takes words, flags a zero axis and scales the axis magnitudes so that the
// largest lies in [2^30, 2^31].
// ----------------------------------------------------------------------------
module aavr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [aavr_pkg::W-1:0]       vec_x,
	input  logic signed [aavr_pkg::W-1:0]       vec_y,
	input  logic signed [aavr_pkg::W-1:0]       vec_z,
	input  logic signed [aavr_pkg::W-1:0]       axis_x,
	input  logic signed [aavr_pkg::W-1:0]       axis_y,
	input  logic signed [aavr_pkg::W-1:0]       axis_z,
	input  logic signed [aavr_pkg::ANG_W-1:0]   angle,
	output aavr_pkg::item_t                     item,
	output logic                                item_valid,
	input  logic                                item_ready
);

	logic                               v_s1, v_s2;
	logic [2:0][aavr_pkg::W-1:0]        vec_s1, mag_s1;
	logic [2:0]                         neg_s1;
	logic [aavr_pkg::W-1:0]             max_s1;
	logic signed [aavr_pkg::ANG_W-1:0]  angle_s1;
	aavr_pkg::item_t                    item_s2;

	logic                               en1, en2;
	logic [2:0][aavr_pkg::W-1:0]        axis_v, mag_c;
	logic [aavr_pkg::W-1:0]             max01, max_c;
	logic [4:0]                         msb, sh;
	aavr_pkg::item_t                    item_c;

	assign en2  = !v_s2 || item_ready;
	assign en1  = !v_s1 || en2;
	assign full = !en1;

	assign item       = item_s2;
	assign item_valid = v_s2;

	always_comb begin
		axis_v = {axis_z, axis_y, axis_x};
		for (int l = 0; l < 3; l++) begin
			mag_c[l] = axis_v[l][aavr_pkg::W-1] ? aavr_pkg::W'(-$signed(axis_v[l])) : axis_v[l];
		end
		max01 = (mag_c[1] > mag_c[0]) ? mag_c[1] : mag_c[0];
		max_c = (mag_c[2] > max01) ? mag_c[2] : max01;
	end

	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < aavr_pkg::W; i++) begin
			if (max_s1[i]) begin
				msb = 5'(i);
			end
		end
		sh = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
		item_c.vec   = vec_s1;
		item_c.neg   = neg_s1;
		item_c.zero  = (max_s1 == '0);
		item_c.angle = angle_s1;
		for (int l = 0; l < 3; l++) begin
			item_c.mag[l] = mag_s1[l] << sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= push;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			vec_s1   <= {vec_z, vec_y, vec_x};
			mag_s1   <= mag_c;
			neg_s1   <= {axis_z[aavr_pkg::W-1], axis_y[aavr_pkg::W-1], axis_x[aavr_pkg::W-1]};
			max_s1   <= max_c;
			angle_s1 <= angle;
		end
		if (en2) begin
			item_s2 <= item_c;
		end
	end

endmodule

// File: hdl/aavr_queue.sv
// ----------------------------------------------------------------------------
// aavr_queue - short word queue between front end and back end
// Register-based first-in first-out store of prepared words.
// ----------------------------------------------------------------------------
module aavr_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  aavr_pkg::item_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output aavr_pkg::item_t rd_data,
	output logic            empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	aavr_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hdl/aavr_back.sv
// ----------------------------------------------------------------------------
// aavr_back - arithmetic pipeline of the rotation unit
// Square root and divide normalise the axis, with the sine/cosine stages run
// alongside the square root; the Rodrigues terms follow, then summing and clamping.
// ----------------------------------------------------------------------------
module aavr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  aavr_pkg::item_t in_item,
	input  logic            in_valid,
	output logic            in_take,
	output aavr_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_pop
);

	localparam int SQ  = aavr_pkg::SQ_STEPS;
	localparam int DV  = aavr_pkg::DIV_STEPS;
	localparam int CD  = aavr_pkg::CORDIC_STEPS;
	localparam int TW  = aavr_pkg::T_W;
	localparam int CW  = aavr_pkg::CS_W;
	localparam int RW  = aavr_pkg::R_W;
	localparam int LAT = 2 + SQ + DV + 5;

	logic [LAT-1:0] vld_q;
	logic           adv;

	// stage 1
	aavr_pkg::item_t        it_s1;
	logic [2:0][63:0]       sq_s1;
	logic signed [TW-1:0]   t_s1;
	logic                   neg_s1;

	// square root and sine/cosine chain, index 0 is stage 2
	aavr_pkg::item_t        it_sq   [SQ+1];
	logic [63:0]            rem_sq  [SQ+1];
	logic [31:0]            root_sq [SQ+1];
	logic signed [CW-1:0]   cx_sq   [SQ+1];
	logic signed [CW-1:0]   cy_sq   [SQ+1];
	logic signed [TW-1:0]   ct_sq   [SQ+1];
	logic                   cneg_sq [SQ+1];
	logic [63:0]            rem_nx  [SQ];
	logic [31:0]            root_nx [SQ];
	logic signed [CW-1:0]   cx_nx   [SQ];
	logic signed [CW-1:0]   cy_nx   [SQ];
	logic signed [TW-1:0]   ct_nx   [SQ];

	// divide chain
	aavr_pkg::item_t        it_dv   [DV];
	logic [62:0]            rem_dv  [3][DV];
	logic [30:0]            q_dv    [3][DV];
	logic [31:0]            len_dv  [DV];
	logic signed [CW-1:0]   c_dv    [DV];
	logic signed [CW-1:0]   s_dv    [DV];
	logic [62:0]            rem_di  [3][DV];
	logic [30:0]            q_di    [3][DV];
	logic [31:0]            len_di  [DV];
	logic [62:0]            rem_dn  [3][DV];
	logic [30:0]            q_dn    [3][DV];

	// product stages
	aavr_pkg::item_t        it_p1, it_p2, it_p3, it_p4;
	logic signed [31:0]     k_p1 [3];
	logic signed [31:0]     k_p2 [3];
	logic signed [63:0]     pr_p1 [3][3];
	logic signed [CW-1:0]   c_p1, s_p1, c_p2, s_p2;
	logic signed [CW:0]     omc_p1, omc_p2, omc_p3;
	logic signed [RW-1:0]   cr_p2 [3];
	logic signed [RW-1:0]   dot_p2;
	logic signed [RW-1:0]   vc_p3 [3];
	logic signed [RW-1:0]   cs_p3 [3];
	logic signed [RW-1:0]   kd_p3 [3];
	logic signed [RW-1:0]   vc_p4 [3];
	logic signed [RW-1:0]   cs_p4 [3];
	logic signed [RW-1:0]   kdo_p4 [3];
	aavr_pkg::res_t         res_q;

	logic [2:0][63:0]       sq_c;
	logic signed [TW-1:0]   tw_c, tf_c;
	logic                   fneg_c;
	logic signed [CW-1:0]   cfin_c, sfin_c;
	logic signed [31:0]     k_c [3];
	logic signed [RW-1:0]   cr_c [3];
	logic signed [RW-1:0]   dot_c;
	logic signed [RW-1:0]   vc_c [3];
	logic signed [RW-1:0]   cs_c [3];
	logic signed [RW-1:0]   kd_c [3];
	logic signed [RW-1:0]   kdo_c [3];
	aavr_pkg::res_t         res_c;

	assign adv       = !vld_q[LAT-1] || res_pop;
	assign in_take   = adv && in_valid;
	assign res       = res_q;
	assign res_valid = vld_q[LAT-1];

	// square the magnitudes, fold the angle into [-pi/2, pi/2]
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sq_c[l] = 64'(in_item.mag[l]) * 64'(in_item.mag[l]);
		end
		tw_c   = TW'(in_item.angle) <<< 14;
		tf_c   = tw_c;
		fneg_c = 1'b0;
		if (tw_c > aavr_pkg::HALF_PI_Q30) begin
			tf_c   = tw_c - aavr_pkg::PI_Q30;
			fneg_c = 1'b1;
		end else if (tw_c < -aavr_pkg::HALF_PI_Q30) begin
			tf_c   = tw_c + aavr_pkg::PI_Q30;
			fneg_c = 1'b1;
		end
	end

	// one root bit per stage, and one rotation step in each of the first CORDIC_STEPS stages
	always_comb begin
		logic [65:0] cand;
		int          j;
		for (int k = 0; k < SQ; k++) begin
			j    = SQ - 1 - k;
			cand = (66'(root_sq[k]) << (j + 1)) + (66'd1 << (2 * j));
			if (66'(rem_sq[k]) >= cand) begin
				rem_nx[k]  = 64'(66'(rem_sq[k]) - cand);
				root_nx[k] = root_sq[k] | (32'd1 << j);
			end else begin
				rem_nx[k]  = rem_sq[k];
				root_nx[k] = root_sq[k];
			end
			if (k < CD) begin
				if (!ct_sq[k][TW-1]) begin
					cx_nx[k] = cx_sq[k] - (cy_sq[k] >>> k);
					cy_nx[k] = cy_sq[k] + (cx_sq[k] >>> k);
					ct_nx[k] = ct_sq[k] - $signed(TW'(aavr_pkg::atan_q30(5'(k))));
				end else begin
					cx_nx[k] = cx_sq[k] + (cy_sq[k] >>> k);
					cy_nx[k] = cy_sq[k] - (cx_sq[k] >>> k);
					ct_nx[k] = ct_sq[k] + $signed(TW'(aavr_pkg::atan_q30(5'(k))));
				end
			end else begin
				cx_nx[k] = cx_sq[k];
				cy_nx[k] = cy_sq[k];
				ct_nx[k] = ct_sq[k];
			end
		end
	end

	// one quotient bit per stage, three lanes
	always_comb begin
		logic [62:0] d;
		int          j;
		cfin_c = cneg_sq[SQ] ? -cx_sq[SQ] : cx_sq[SQ];
		sfin_c = cneg_sq[SQ] ? -cy_sq[SQ] : cy_sq[SQ];
		for (int k = 0; k < DV; k++) begin
			j = DV - 1 - k;
			len_di[k] = (k == 0) ? root_sq[SQ] : len_dv[k-1];
			d = 63'(len_di[k]) << j;
			for (int l = 0; l < 3; l++) begin
				if (k == 0) begin
					rem_di[l][k] = (63'(it_sq[SQ].mag[l]) << 30) + 63'(root_sq[SQ] >> 1);
					q_di[l][k]   = '0;
				end else begin
					rem_di[l][k] = rem_dv[l][k-1];
					q_di[l][k]   = q_dv[l][k-1];
				end
				if (rem_di[l][k] >= d) begin
					rem_dn[l][k] = rem_di[l][k] - d;
					q_dn[l][k]   = q_di[l][k] | (31'd1 << j);
				end else begin
					rem_dn[l][k] = rem_di[l][k];
					q_dn[l][k]   = q_di[l][k];
				end
			end
		end
	end

	// signed axis, then cross and dot sums, then the three terms
	always_comb begin
		logic signed [64:0] diff [3];
		logic signed [65:0] dsum;
		for (int l = 0; l < 3; l++) begin
			k_c[l] = it_dv[DV-1].neg[l] ? -$signed({1'b0, q_dv[l][DV-1]})
			                            : $signed({1'b0, q_dv[l][DV-1]});
		end
		diff[0] = 65'(pr_p1[1][2]) - 65'(pr_p1[2][1]);
		diff[1] = 65'(pr_p1[2][0]) - 65'(pr_p1[0][2]);
		diff[2] = 65'(pr_p1[0][1]) - 65'(pr_p1[1][0]);
		dsum    = 66'(pr_p1[0][0]) + 66'(pr_p1[1][1]) + 66'(pr_p1[2][2]);
		for (int l = 0; l < 3; l++) begin
			cr_c[l] = RW'(diff[l] >>> 30);
		end
		dot_c = RW'(dsum >>> 30);
		for (int l = 0; l < 3; l++) begin
			vc_c[l]  = RW'((80'($signed(it_p2.vec[l])) * 80'(c_p2)) >>> 30);
			cs_c[l]  = RW'((80'(cr_p2[l]) * 80'(s_p2)) >>> 30);
			kd_c[l]  = RW'((80'(k_p2[l]) * 80'(dot_p2)) >>> 30);
			kdo_c[l] = RW'((80'(kd_p3[l]) * 80'(omc_p3)) >>> 30);
		end
	end

	// sum and clamp
	always_comb begin
		logic signed [RW+1:0] sum;
		logic                 hi, lo;
		res_c.saturated = 1'b0;
		res_c.axis_zero = it_p4.zero;
		for (int l = 0; l < 3; l++) begin
			sum = (RW+2)'(vc_p4[l]) + (RW+2)'(cs_p4[l]) + (RW+2)'(kdo_p4[l]);
			hi  = !sum[RW+1] && (|sum[RW:aavr_pkg::W-1]);
			lo  = sum[RW+1] && !(&sum[RW:aavr_pkg::W-1]);
			if (it_p4.zero) begin
				res_c.vout[l] = it_p4.vec[l];
			end else if (hi) begin
				res_c.vout[l] = aavr_pkg::Q_MAX;
			end else if (lo) begin
				res_c.vout[l] = aavr_pkg::Q_MIN;
			end else begin
				res_c.vout[l] = sum[aavr_pkg::W-1:0];
			end
			if (!it_p4.zero && (hi || lo)) begin
				res_c.saturated = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1  <= in_item;
			sq_s1  <= sq_c;
			t_s1   <= tf_c;
			neg_s1 <= fneg_c;

			it_sq[0]   <= it_s1;
			rem_sq[0]  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			root_sq[0] <= '0;
			cx_sq[0]   <= aavr_pkg::GAIN_Q30;
			cy_sq[0]   <= '0;
			ct_sq[0]   <= t_s1;
			cneg_sq[0] <= neg_s1;
			for (int k = 0; k < SQ; k++) begin
				it_sq[k+1]   <= it_sq[k];
				rem_sq[k+1]  <= rem_nx[k];
				root_sq[k+1] <= root_nx[k];
				cx_sq[k+1]   <= cx_nx[k];
				cy_sq[k+1]   <= cy_nx[k];
				ct_sq[k+1]   <= ct_nx[k];
				cneg_sq[k+1] <= cneg_sq[k];
			end

			for (int k = 0; k < DV; k++) begin
				it_dv[k]  <= (k == 0) ? it_sq[SQ] : it_dv[k-1];
				c_dv[k]   <= (k == 0) ? cfin_c : c_dv[k-1];
				s_dv[k]   <= (k == 0) ? sfin_c : s_dv[k-1];
				len_dv[k] <= len_di[k];
				for (int l = 0; l < 3; l++) begin
					rem_dv[l][k] <= rem_dn[l][k];
					q_dv[l][k]   <= q_dn[l][k];
				end
			end

			it_p1  <= it_dv[DV-1];
			c_p1   <= c_dv[DV-1];
			s_p1   <= s_dv[DV-1];
			omc_p1 <= (CW+1)'(aavr_pkg::ONE_Q30) - (CW+1)'(c_dv[DV-1]);
			for (int a = 0; a < 3; a++) begin
				k_p1[a] <= k_c[a];
				for (int b = 0; b < 3; b++) begin
					pr_p1[a][b] <= 64'(k_c[a]) * 64'($signed(it_dv[DV-1].vec[b]));
				end
			end

			it_p2  <= it_p1;
			c_p2   <= c_p1;
			s_p2   <= s_p1;
			omc_p2 <= omc_p1;
			dot_p2 <= dot_c;
			for (int l = 0; l < 3; l++) begin
				k_p2[l]  <= k_p1[l];
				cr_p2[l] <= cr_c[l];
			end

			it_p3  <= it_p2;
			omc_p3 <= omc_p2;
			for (int l = 0; l < 3; l++) begin
				vc_p3[l] <= vc_c[l];
				cs_p3[l] <= cs_c[l];
				kd_p3[l] <= kd_c[l];
			end

			it_p4 <= it_p3;
			for (int l = 0; l < 3; l++) begin
				vc_p4[l]  <= vc_p3[l];
				cs_p4[l]  <= cs_p3[l];
				kdo_p4[l] <= kdo_c[l];
			end

			res_q <= res_c;
		end
	end

endmodule

// File: hdl/axis_angle_vector_rotation_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_unit - rotate a 3D vector about an axis
// Rotates a signed Q16.16 vector about an axis of any length by an angle in
// radians (Q3.16, folded by pi), with Rodrigues' formula; results saturate
// to Q16.16 and a zero axis passes the vector through with axis_zero set.
// One word is taken per clock and one result leaves per clock while pop
// keeps up; the 32-stage square-root and 31-stage divide pipelines
// normalise the axis. The pipeline holds while an unread result sits on
// the outputs, and a short queue behind the input stage absorbs the stall.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [aavr_pkg::W-1:0]       vec_x,
	input  logic signed [aavr_pkg::W-1:0]       vec_y,
	input  logic signed [aavr_pkg::W-1:0]       vec_z,
	input  logic signed [aavr_pkg::W-1:0]       axis_x,
	input  logic signed [aavr_pkg::W-1:0]       axis_y,
	input  logic signed [aavr_pkg::W-1:0]       axis_z,
	input  logic signed [aavr_pkg::ANG_W-1:0]   angle,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [aavr_pkg::W-1:0]       out_x,
	output logic signed [aavr_pkg::W-1:0]       out_y,
	output logic signed [aavr_pkg::W-1:0]       out_z,
	output logic                                axis_zero,
	output logic                                saturated
);

	aavr_pkg::item_t fr_item, q_item;
	aavr_pkg::res_t  res;
	logic            fr_valid, q_full, q_empty, q_take, res_valid;

	aavr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.axis_x     (axis_x),
		.axis_y     (axis_y),
		.axis_z     (axis_z),
		.angle      (angle),
		.item       (fr_item),
		.item_valid (fr_valid),
		.item_ready (!q_full)
	);

	aavr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_valid),
		.wr_data (fr_item),
		.full    (q_full),
		.rd_en   (q_take),
		.rd_data (q_item),
		.empty   (q_empty)
	);

	aavr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (q_item),
		.in_valid  (!q_empty),
		.in_take   (q_take),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	assign empty     = !res_valid;
	assign out_x     = $signed(res.vout[0]);
	assign out_y     = $signed(res.vout[1]);
	assign out_z     = $signed(res.vout[2]);
	assign axis_zero = res.axis_zero;
	assign saturated = res.saturated;

endmodule

// File: hdl/aavr_checker.sv
// ----------------------------------------------------------------------------
// aavr_checker - port checks for the rotation unit
// Watches the result side of the top level and is bound to it.
// ----------------------------------------------------------------------------
module aavr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic signed [aavr_pkg::W-1:0] out_x,
	input logic signed [aavr_pkg::W-1:0] out_y,
	input logic signed [aavr_pkg::W-1:0] out_z,
	input logic                          axis_zero,
	input logic                          saturated
);

	a_zero_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && axis_zero) |-> !saturated)
		else $error("zero axis word flagged as saturated");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && saturated) |->
		(out_x == aavr_pkg::Q_MAX || out_x == aavr_pkg::Q_MIN ||
		 out_y == aavr_pkg::Q_MAX || out_y == aavr_pkg::Q_MIN ||
		 out_z == aavr_pkg::Q_MAX || out_z == aavr_pkg::Q_MIN))
		else $error("saturated word carries no clamped component");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_x) && $stable(out_y) &&
		$stable(out_z) && $stable(axis_zero) && $stable(saturated)))
		else $error("waiting result word changed before pop");

endmodule

bind axis_angle_vector_rotation_unit aavr_checker u_aavr_checker (.*);
